@@ src/tf2x_pkg.sv @@
// Shared types, constants and helper functions for the Threefry-2x32 pipeline.
// Depends on nothing; every other file imports it.
package tf2x_pkg;

    localparam logic [31:0] TF_PARITY = 32'h1BD1_1BDA;
    localparam int unsigned TF_GROUPS = 5;
    localparam int unsigned TF_ROUNDS_PER_GROUP = 4;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t key_low;
        word_t key_high;
        word_t count_low;
        word_t count_high;
    } item_t;

    typedef struct packed {
        word_t rand_low;
        word_t rand_high;
    } result_t;

    // Working state carried along the pipeline: the two data words and the
    // three key schedule words.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t ks0;
        word_t ks1;
        word_t ks2;
    } tf_state_t;

    // Rotation distances; first half for odd groups, second half for even ones.
    function automatic int unsigned tf_rot(input int unsigned idx);
        int unsigned d;
        case (idx % 8)
            0: d = 13;
            1: d = 15;
            2: d = 26;
            3: d = 6;
            4: d = 17;
            5: d = 29;
            6: d = 16;
            7: d = 24;
            default: d = 13;
        endcase
        return d;
    endfunction

    // Pick key schedule word idx mod 3.
    function automatic word_t ks_sel(input tf_state_t s, input int unsigned idx);
        word_t w;
        case (idx % 3)
            0: w = s.ks0;
            1: w = s.ks1;
            2: w = s.ks2;
            default: w = s.ks0;
        endcase
        return w;
    endfunction

endpackage

@@ src/tf2x_round.sv @@
// One registered mix round: add, rotate by a fixed distance, xor.
// Depends on tf2x_pkg.
module tf2x_round
    import tf2x_pkg::*;
#(
    parameter int unsigned ROT_DIST = 13  // 1..31
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      vld,
    input  tf_state_t state,
    output logic      vld_q,
    output tf_state_t state_q
);

    logic      vld_reg;
    tf_state_t state_reg;
    tf_state_t state_next;
    word_t     sum;
    word_t     rot;

    always_comb
    begin
        sum        = state.a + state.b;
        rot        = (state.b << ROT_DIST) | (state.b >> (32 - ROT_DIST));
        state_next = state;
        state_next.a = sum;
        state_next.b = rot ^ sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign vld_q   = vld_reg;
    assign state_q = state_reg;

endmodule

@@ src/tf2x_inject.sv @@
// One registered key injection after a group of four rounds.
// Depends on tf2x_pkg.
module tf2x_inject
    import tf2x_pkg::*;
#(
    parameter int unsigned GROUP = 1  // 1..TF_GROUPS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      vld,
    input  tf_state_t state,
    output logic      vld_q,
    output tf_state_t state_q
);

    localparam word_t GROUP_W = 32'(GROUP);

    logic      vld_reg;
    tf_state_t state_reg;
    tf_state_t state_next;

    always_comb
    begin
        state_next   = state;
        state_next.a = state.a + ks_sel(state, GROUP);
        state_next.b = state.b + ks_sel(state, GROUP + 1) + GROUP_W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign vld_q   = vld_reg;
    assign state_q = state_reg;

endmodule

@@ src/threefry2x32_block_cipher.sv @@
// Threefry-2x32, 20 rounds, as a 26-stage pipeline: one key set-up stage,
// then per group four round stages and one key injection stage.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset clears every stage valid bit; payload registers are left as they are.
// Depends on tf2x_pkg, tf2x_round and tf2x_inject.
module threefry2x32_block_cipher
    import tf2x_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,

    // Input transactions: key pair and counter pair
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,

    // Output transactions: cipher output pair
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int unsigned STAGES_PER_GROUP = TF_ROUNDS_PER_GROUP + 1;
    localparam int unsigned NUM_STAGES       = 1 + TF_GROUPS * STAGES_PER_GROUP;
    localparam int unsigned LAST             = NUM_STAGES - 1;

    // Stage outputs; entry 0 is the key set-up register.
    logic [NUM_STAGES-1:0] vld;
    tf_state_t             st [NUM_STAGES];

    // The whole pipeline advances together. Hold everything while the last
    // stage has a transaction that the receiver does not take; bubbles
    // inside the pipeline simply travel with their cleared valid bits.
    logic hold;
    logic en;

    assign hold       = vld[LAST] && result_stall;
    assign en         = !hold;
    assign item_stall = hold;

    // Key set-up: derive the parity word and add the first two key words
    // into the counter.
    logic      vld0_reg;
    tf_state_t st0_reg;
    tf_state_t st0_next;

    always_comb
    begin
        st0_next.ks0 = item.key_low;
        st0_next.ks1 = item.key_high;
        st0_next.ks2 = TF_PARITY ^ item.key_low ^ item.key_high;
        st0_next.a   = item.count_low + item.key_low;
        st0_next.b   = item.count_high + item.key_high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st0_reg <= st0_next;
        end
    end

    assign vld[0] = vld0_reg;
    assign st[0]  = st0_reg;

    // Five groups of four rounds, each followed by a key injection.
    // Odd groups use the first half of the rotation table, even groups
    // the second half.
    for (genvar g = 0; g < TF_GROUPS; g++)
    begin : g_group
        for (genvar r = 0; r < TF_ROUNDS_PER_GROUP; r++)
        begin : g_round
            localparam int unsigned IDX = 1 + g * STAGES_PER_GROUP + r;

            tf2x_round #(
                .ROT_DIST (tf_rot((g % 2) * TF_ROUNDS_PER_GROUP + r))
            ) u_round (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .vld     (vld[IDX-1]),
                .state   (st[IDX-1]),
                .vld_q   (vld[IDX]),
                .state_q (st[IDX])
            );
        end

        localparam int unsigned INJ = 1 + g * STAGES_PER_GROUP + TF_ROUNDS_PER_GROUP;

        tf2x_inject #(
            .GROUP (g + 1)
        ) u_inject (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld     (vld[INJ-1]),
            .state   (st[INJ-1]),
            .vld_q   (vld[INJ]),
            .state_q (st[INJ])
        );
    end

    // The last stage register doubles as the output register.
    assign result_valid     = vld[LAST];
    assign result.rand_low  = st[LAST].a;
    assign result.rand_high = st[LAST].b;

    // A held pipeline keeps every valid bit and the outgoing payload.
    a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> $stable(vld) && $stable(st[LAST]))
        else $error("pipeline moved while held");

    // When the pipeline advances, the first stage takes the input valid.
    a_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !hold |=> vld[0] == $past(item_valid))
        else $error("entry stage valid does not follow accepted input");

    // When the pipeline advances, the output takes the stage before it.
    a_exit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !hold |=> result_valid == $past(vld[LAST-1]))
        else $error("output valid does not follow last stage");

endmodule
